// ===== rtl/lbr_pkg.sv =====
package lbr_pkg;

  localparam int MAX_COMP  = 16;
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = $clog2(MAX_COMP);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIV_W     = WORD_W + FRAC_BITS;
  localparam int PROD_W    = 66;
  localparam int ENTRY_W   = 3 * WORD_W + 3 * (WORD_W - 1) + 1;

  localparam logic signed [WORD_W-1:0] ONE_FX = WORD_W'(1 << FRAC_BITS);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZCAP = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIV_END, S_EV_ADDR, S_EV_DATA,
    S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_KA_C, MOP_T1_CAP, MOP_T2_S, MOP_KD_Q, MOP_TF_RATE
  } mop_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_end;
    mop_t mop;
    logic emit;
    logic next_idx;
    logic clear_eval;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic last;
    logic idx_end;
    logic binds;
  } stat_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[WORD_W-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

// ===== rtl/langmuir_binding_residual_top.sv =====
// Multicomponent Langmuir binding residual. Feed one component per start
// beat (accepted when start is high and busy is low); the beat marked
// last_component ends the evaluation and the block then puts out one residual
// per binding component, each on the result ports for exactly one cycle
// with result_valid high; the receiver cannot stall, so capture every
// beat. A binding component with nonzero capacity first runs the
// bit-serial divider for bound/capacity (one quotient bit per
// cycle over 48 bits). After the last beat each stored component is read
// in S_EV_ADDR and S_EV_DATA, a binding one then in S_MUL1 to S_MUL5 on
// the shared 33x33 multiplier, and S_FINISH closes. kinetic_mode is
// written over the cfg channel, which is always ready; write it only while idle.
module langmuir_binding_residual_top import lbr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] conc_pore,
  input  logic signed [WORD_W-1:0] bound_amount,
  input  logic signed [WORD_W-1:0] bound_rate,
  input  logic                     rate_derivative_present,
  input  logic [WORD_W-2:0]        adsorb_rate,
  input  logic [WORD_W-2:0]        desorb_rate,
  input  logic [WORD_W-2:0]        capacity,
  input  logic                     binds,
  input  logic signed [WORD_W-1:0] time_factor,
  input  logic                     last_component,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_data,
  output logic                     result_valid,
  output logic signed [WORD_W-1:0] residual,
  output logic [IDX_W-1:0]         bound_index,
  output logic [1:0]               status,
  output logic                     last_result
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  lbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  lbr_datapath u_dp (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .st                      (st),
    .conc_pore               (conc_pore),
    .bound_amount            (bound_amount),
    .bound_rate              (bound_rate),
    .rate_derivative_present (rate_derivative_present),
    .adsorb_rate             (adsorb_rate),
    .desorb_rate             (desorb_rate),
    .capacity                (capacity),
    .binds                   (binds),
    .time_factor             (time_factor),
    .last_component          (last_component),
    .cfg_we                  (cfg_valid && cfg_ready),
    .cfg_data                (cfg_data),
    .result_valid            (result_valid),
    .residual                (residual),
    .bound_index             (bound_index),
    .status                  (status),
    .last_result             (last_result)
  );

endmodule

// ===== rtl/lbr_ram.sv =====
module lbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lbr_ctrl.sv =====
module lbr_ctrl import lbr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (st.need_div) state_next = S_DIV;
          else if (st.last) state_next = S_EV_ADDR;
        end
      end
      S_DIV:     if (st.div_done) state_next = S_DIV_END;
      S_DIV_END: state_next = st.last ? S_EV_ADDR : S_IDLE;
      S_EV_ADDR: state_next = st.idx_end ? S_FINISH : S_EV_DATA;
      S_EV_DATA: state_next = st.binds ? S_MUL1 : S_EV_ADDR;
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = S_MUL3;
      S_MUL3:    state_next = S_MUL4;
      S_MUL4:    state_next = S_MUL5;
      S_MUL5:    state_next = S_EV_ADDR;
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    cmd.mop = MOP_NONE;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.load = start;
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_END: cmd.div_end = 1'b1;
      S_EV_ADDR: ;
      S_EV_DATA: begin
        if (st.binds) cmd.mop = MOP_KA_C;
        else cmd.next_idx = 1'b1;
      end
      S_MUL1:    cmd.mop = MOP_T1_CAP;
      S_MUL2:    cmd.mop = MOP_T2_S;
      S_MUL3:    cmd.mop = MOP_KD_Q;
      S_MUL4:    cmd.mop = MOP_TF_RATE;
      S_MUL5: begin
        cmd.emit     = 1'b1;
        cmd.next_idx = 1'b1;
      end
      S_FINISH:  cmd.clear_eval = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/lbr_datapath.sv =====
module lbr_datapath import lbr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    st,
  input  logic signed [WORD_W-1:0] conc_pore,
  input  logic signed [WORD_W-1:0] bound_amount,
  input  logic signed [WORD_W-1:0] bound_rate,
  input  logic                     rate_derivative_present,
  input  logic [WORD_W-2:0]        adsorb_rate,
  input  logic [WORD_W-2:0]        desorb_rate,
  input  logic [WORD_W-2:0]        capacity,
  input  logic                     binds,
  input  logic signed [WORD_W-1:0] time_factor,
  input  logic                     last_component,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  output logic                     result_valid,
  output logic signed [WORD_W-1:0] residual,
  output logic [IDX_W-1:0]         bound_index,
  output logic [1:0]               status,
  output logic                     last_result
);

  logic                     kinetic;
  logic signed [WORD_W-1:0] free_frac;
  logic [CNT_W-1:0]         loaded;
  logic                     zcap;
  logic [MAX_COMP-1:0]      mask;
  logic signed [WORD_W-1:0] tf;
  logic                     last_q;
  logic [CNT_W-1:0]         idx;
  logic [IDX_W-1:0]         res_cnt;

  logic store;
  assign store = (loaded < CNT_W'(MAX_COMP));

  // component store
  logic [ENTRY_W-1:0] wentry, rentry;
  logic signed [WORD_W-1:0] rate_in;
  assign rate_in = rate_derivative_present ? bound_rate : '0;
  assign wentry = {conc_pore, bound_amount, rate_in, adsorb_rate, desorb_rate, capacity, binds};

  lbr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_COMP)) u_store (
    .clk   (clk),
    .we    (cmd.load && store),
    .waddr (loaded[IDX_W-1:0]),
    .wdata (wentry),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rentry)
  );

  logic signed [WORD_W-1:0] e_c, e_q, e_rate;
  logic [WORD_W-2:0]        e_ka, e_kd, e_cap;
  logic                     e_binds;
  assign {e_c, e_q, e_rate, e_ka, e_kd, e_cap, e_binds} = rentry;

  // divider: |q| << FRAC over capacity, one bit a cycle
  logic [WORD_W-1:0] div_rem;
  logic [DIV_W-1:0]  div_sh;
  logic [WORD_W-2:0] div_d;
  logic              div_neg;
  logic [5:0]        div_cnt;
  logic [WORD_W-1:0] rem_s, qmag;
  logic              ge;

  assign qmag  = bound_amount[WORD_W-1] ? (~bound_amount + 1'b1) : bound_amount;
  assign rem_s = {div_rem[WORD_W-2:0], div_sh[DIV_W-1]};
  assign ge    = (rem_s >= {1'b0, div_d});

  logic signed [63:0] quo_s;
  logic signed [WORD_W-1:0] quo;
  assign quo_s = div_neg ? -$signed(64'(div_sh)) : $signed(64'(div_sh));
  assign quo   = sat32(quo_s);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_rem <= '0;
      div_sh  <= {qmag, {FRAC_BITS{1'b0}}};
      div_d   <= capacity;
      div_neg <= bound_amount[WORD_W-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= ge ? (rem_s - {1'b0, div_d}) : rem_s;
      div_sh  <= {div_sh[DIV_W-2:0], ge};
      div_cnt <= div_cnt + 6'd1;
    end
  end

  // shared multiplier with registered product
  logic signed [PROD_W-1:0] p_reg;
  logic signed [63:0]       pf;
  logic signed [WORD_W-1:0] t_reg, pf_sat;
  logic signed [63:0]       d_reg;
  logic                     sat_acc;
  logic signed [32:0]       ma, mb;

  assign pf     = 64'(p_reg >>> FRAC_BITS);
  assign pf_sat = sat32(pf);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mop)
      MOP_KA_C:    begin ma = {2'b0, e_ka}; mb = 33'(e_c); end
      MOP_T1_CAP:  begin ma = 33'(pf_sat); mb = {2'b0, e_cap}; end
      MOP_T2_S:    begin ma = 33'(pf_sat); mb = 33'(free_frac); end
      MOP_KD_Q:    begin ma = {2'b0, e_kd}; mb = 33'(e_q); end
      MOP_TF_RATE: begin ma = 33'(tf); mb = 33'(e_rate); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mop != MOP_NONE) p_reg <= ma * mb;
    case (cmd.mop)
      MOP_KA_C:    sat_acc <= 1'b0;
      MOP_T1_CAP,
      MOP_T2_S:    sat_acc <= sat_acc | ovf32(pf);
      MOP_KD_Q: begin
        t_reg   <= pf_sat;
        sat_acc <= sat_acc | ovf32(pf);
      end
      MOP_TF_RATE: d_reg <= pf;
      default: ;
    endcase
  end

  // residual sum
  logic signed [63:0] r_sum;
  logic               more_binding;
  logic [MAX_COMP-1:0] mask_hi;
  assign r_sum = d_reg - 64'(t_reg) + (kinetic ? pf : 64'sd0);
  assign mask_hi = mask >> (idx + CNT_W'(1));
  assign more_binding = |mask_hi;

  // evaluation state
  always_ff @(posedge clk) begin
    if (rst) begin
      kinetic   <= 1'b0;
      free_frac <= ONE_FX;
      loaded    <= '0;
      zcap      <= 1'b0;
      mask      <= '0;
      idx       <= '0;
      res_cnt   <= '0;
      last_q    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cfg_we) kinetic <= cfg_data;
      if (cmd.load) begin
        last_q <= last_component;
        tf     <= time_factor;
        if (store) begin
          mask[loaded[IDX_W-1:0]] <= binds;
          loaded <= loaded + CNT_W'(1);
          if (binds && capacity == '0) zcap <= 1'b1;
        end
      end
      if (cmd.div_end) free_frac <= sat32(64'(free_frac) - 64'(quo));
      if (cmd.next_idx) idx <= idx + CNT_W'(1);
      if (cmd.emit) res_cnt <= res_cnt + IDX_W'(1);
      if (cmd.clear_eval) begin
        free_frac <= ONE_FX;
        loaded    <= '0;
        zcap      <= 1'b0;
        mask      <= '0;
        idx       <= '0;
        res_cnt   <= '0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      residual    <= sat32(r_sum);
      bound_index <= res_cnt;
      status      <= zcap ? ST_ZCAP : ((sat_acc || ovf32(r_sum)) ? ST_SAT : ST_OK);
      last_result <= !more_binding;
    end
  end

  // take the last flag straight from the beat being accepted
  assign st.need_div = store && binds && (capacity != '0);
  assign st.div_done = (div_cnt == 6'(DIV_W - 1));
  assign st.last     = cmd.load ? last_component : last_q;
  assign st.idx_end  = (idx == loaded);
  assign st.binds    = e_binds;

endmodule

// ===== bench/lbr_checker.sv =====
module lbr_checker import lbr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [WORD_W-1:0] conc_pore,
  input  logic signed [WORD_W-1:0] bound_amount,
  input  logic signed [WORD_W-1:0] bound_rate,
  input  logic                     rate_derivative_present,
  input  logic [WORD_W-2:0]        adsorb_rate,
  input  logic [WORD_W-2:0]        desorb_rate,
  input  logic [WORD_W-2:0]        capacity,
  input  logic                     binds,
  input  logic signed [WORD_W-1:0] time_factor,
  input  logic                     last_component,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic                     cfg_data,
  input  logic                     result_valid,
  input  logic signed [WORD_W-1:0] residual,
  input  logic [IDX_W-1:0]         bound_index,
  input  logic [1:0]               status,
  input  logic                     last_result,
  output int                       errors,
  output int                       pending
);

  typedef struct {
    logic signed [WORD_W-1:0] res;
    logic [IDX_W-1:0]         idx;
    logic [1:0]               st;
    logic                     lst;
  } residual_t;

  residual_t residual_q[$];

  // shadow copy of the component stores and the running evaluation
  longint conc_m[MAX_COMP];
  longint amt_m[MAX_COMP];
  longint rate_m[MAX_COMP];
  longint ka_m[MAX_COMP];
  longint kd_m[MAX_COMP];
  longint cap_m[MAX_COMP];
  bit     binds_m[MAX_COMP];
  longint free_frac;
  int     n_loaded;
  bit     zcap_seen;
  bit     kinetic;

  function automatic longint clip32(input longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // product of two fixed-point values, floored and clipped
  function automatic longint fx_mul(input longint a, input longint b, inout bit f);
    return clip32((a * b) >>> FRAC_BITS, f);
  endfunction

  task automatic load_component();
    longint c, q, cap, quo;
    int     n;
    bit     r;
    residual_t e;
    c   = longint'(conc_pore);
    q   = longint'(bound_amount);
    cap = longint'({1'b0, capacity});
    r   = 0;
    if (n_loaded < MAX_COMP) begin
      conc_m[n_loaded]  = c;
      amt_m[n_loaded]   = q;
      rate_m[n_loaded]  = rate_derivative_present ? longint'(bound_rate) : 0;
      ka_m[n_loaded]    = longint'({1'b0, adsorb_rate});
      kd_m[n_loaded]    = longint'({1'b0, desorb_rate});
      cap_m[n_loaded]   = cap;
      binds_m[n_loaded] = binds;
      if (binds) begin
        if (cap == 0) begin
          zcap_seen = 1;
        end else begin
          quo = clip32((q <<< FRAC_BITS) / cap, r);
          free_frac = clip32(free_frac - quo, r);
        end
      end
      n_loaded++;
    end
    // emit one residual per binding component on the closing beat
    if (last_component) begin
      n = 0;
      for (int i = 0; i < n_loaded && n < MAX_COMP; i++) begin
        longint t, rr;
        bit sat;
        if (binds_m[i]) begin
          sat = 0;
          t  = fx_mul(ka_m[i], conc_m[i], sat);
          t  = fx_mul(t, cap_m[i], sat);
          t  = fx_mul(t, free_frac, sat);
          rr = ((kd_m[i] * amt_m[i]) >>> FRAC_BITS) - t;
          if (kinetic) rr = rr + ((longint'(time_factor) * rate_m[i]) >>> FRAC_BITS);
          rr    = clip32(rr, sat);
          e.res = rr[WORD_W-1:0];
          e.idx = n[IDX_W-1:0];
          e.st  = zcap_seen ? ST_ZCAP : (sat ? ST_SAT : ST_OK);
          e.lst = 0;
          residual_q.push_back(e);
          n++;
        end
      end
      if (n > 0) residual_q[$].lst = 1;
      free_frac = longint'(ONE_FX);
      n_loaded  = 0;
      zcap_seen = 0;
    end
  endtask

  assign pending = residual_q.size();

  always @(posedge clk) begin
    residual_t e;
    if (rst) begin
      residual_q.delete();
      free_frac = longint'(ONE_FX);
      n_loaded  = 0;
      zcap_seen = 0;
      kinetic   = 0;
      errors   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) kinetic = cfg_data;
      if (start && !busy) load_component();
      // compare each result beat with the oldest expectation
      if (result_valid) begin
        if (residual_q.size() == 0) begin
          $error("unexpected result beat: residual %0d", residual);
          errors <= errors + 1;
        end else begin
          e = residual_q.pop_front();
          if (residual !== e.res || bound_index !== e.idx || status !== e.st ||
              last_result !== e.lst) begin
            errors <= errors + 1;
            if (residual !== e.res)
              $error("residual: expected %0d, got %0d", e.res, residual);
            if (bound_index !== e.idx)
              $error("bound_index: expected %0d, got %0d", e.idx, bound_index);
            if (status !== e.st)
              $error("status: expected %0d, got %0d", e.st, status);
            if (last_result !== e.lst)
              $error("last_result: expected %0d, got %0d", e.lst, last_result);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import lbr_pkg::*;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     start = 0;
  logic                     busy;
  logic signed [WORD_W-1:0] conc_pore = 0;
  logic signed [WORD_W-1:0] bound_amount = 0;
  logic signed [WORD_W-1:0] bound_rate = 0;
  logic                     rate_derivative_present = 0;
  logic [WORD_W-2:0]        adsorb_rate = 0;
  logic [WORD_W-2:0]        desorb_rate = 0;
  logic [WORD_W-2:0]        capacity = 0;
  logic                     binds = 0;
  logic signed [WORD_W-1:0] time_factor = 0;
  logic                     last_component = 0;
  logic                     cfg_valid = 0;
  logic                     cfg_ready;
  logic                     cfg_data = 0;
  logic                     result_valid;
  logic signed [WORD_W-1:0] residual;
  logic [IDX_W-1:0]         bound_index;
  logic [1:0]               status;
  logic                     last_result;
  int                       errors;
  int                       pending;
  int                       items_sent = 0;
  int                       quiet_cycles = 0;
  bit                       calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  langmuir_binding_residual_top dut (.*);

  lbr_checker chk (.*);

  // abort when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_signed(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 393216)) - 32'd196608;
      default: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [30:0] pick_pos(input int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 262144);
      default: v = ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h0;
    endcase
    return v[30:0];
  endfunction

  // present one beat and hold it until accepted
  task automatic send(input logic [31:0] c, q, qd, input logic qdp,
                      input logic [30:0] ka, kd, cap, input logic b,
                      input logic [31:0] tf, input logic lst);
    start                   <= 1;
    conc_pore               <= c;
    bound_amount            <= q;
    bound_rate              <= qd;
    rate_derivative_present <= qdp;
    adsorb_rate             <= ka;
    desorb_rate             <= kd;
    capacity                <= cap;
    binds                   <= b;
    time_factor             <= tf;
    last_component          <= lst;
    do @(posedge clk); while (busy);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 23) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // drop start and wait until the block has drained
  task automatic drain();
    start <= 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_eval();
    int n, m;
    logic [30:0] cap;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
    m = $urandom_range(0, 9);
    m = (m < 6) ? 1 : ((m < 9) ? 0 : 2);
    for (int i = 0; i < n; i++) begin
      cap = ($urandom_range(0, 19) == 0) ? 31'd0 : pick_pos(m) | 31'd1;
      send(pick_signed(m), pick_signed(m), pick_signed(m), 1'($urandom_range(0, 1)),
           pick_pos(m), pick_pos(m), cap, $urandom_range(0, 4) != 0,
           pick_signed(m), i == n - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_mode(1);
    // extremes: largest values, then smallest
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 31'h7fffffff, 31'h7fffffff,
         31'h7fffffff, 1, 32'h7fffffff, 1);
    send(32'h80000000, 32'h80000000, 32'h80000000, 1, 31'h0, 31'h0, 31'h1, 1,
         32'h80000000, 1);
    // zero capacity beside a normal component, rate not supplied
    send(32'h00010000, 32'h00008000, 32'h00020000, 0, 31'h00010000, 31'h00010000,
         31'h00040000, 1, 32'h00010000, 0);
    send(32'h00020000, 32'h00010000, 32'h00010000, 1, 31'h00008000, 31'h00020000,
         31'h0, 1, 32'h00010000, 1);
    // no binding component at all
    send(32'h00010000, 32'h00010000, 32'h0, 1, 31'h00010000, 31'h00010000,
         31'h00010000, 0, 32'h0, 0);
    send(32'h00010000, 32'h00010000, 32'h0, 1, 31'h00010000, 31'h00010000,
         31'h00010000, 0, 32'h0, 1);
    drain();
    write_mode(0);
    // more components than the stores hold, all binding
    for (int i = 0; i < 18; i++)
      send(pick_signed(1), pick_signed(1), pick_signed(1), 1, pick_pos(1),
           pick_pos(1), pick_pos(1) | 31'd1, 1, pick_signed(1), i == 17);
    drain();
    while (items_sent < 500) begin
      random_eval();
      calm = (items_sent > 250 && items_sent < 340);
      if (items_sent > 120 && items_sent < 140) drain();
      if ($urandom_range(0, 14) == 0) begin
        drain();
        write_mode(1'($urandom_range(0, 1)));
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== langmuir_binding_residual_top.f =====
rtl/lbr_pkg.sv
rtl/lbr_ram.sv
rtl/lbr_ctrl.sv
rtl/lbr_datapath.sv
rtl/langmuir_binding_residual_top.sv
bench/lbr_checker.sv
bench/tb_top.sv
